/* rtl/e2r_pkg.sv */
package e2r_pkg;

    // Q30 arithmetic constants
    localparam int unsigned QW = 31;                 // width holding 0..2^30
    localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314857;
    localparam logic [QW-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [QW-1:0] Q30_HALF = 31'h2000_0000;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } t_in;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_out;

    // Horner divisors, sine then cosine, one per step
    function automatic logic [7:0] ks(input int unsigned i);
        case (i)
            0: ks = 8'd110;
            1: ks = 8'd72;
            2: ks = 8'd42;
            3: ks = 8'd20;
            default: ks = 8'd6;
        endcase
    endfunction

    function automatic logic [7:0] kc(input int unsigned i);
        case (i)
            0: kc = 8'd132;
            1: kc = 8'd90;
            2: kc = 8'd56;
            3: kc = 8'd30;
            default: kc = 8'd12;
        endcase
    endfunction

    // (x2*t + 2^29) >> 30, operands at most 2^30
    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = a * b + {{QW{1'b0}}, Q30_HALF};
        qmul = p[QW+29:30];
    endfunction

    // signed round-half-up of magnitude by a constant shift
    function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                  input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        rshift = v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

/* rtl/e2r_sincos.sv */
// Pipelined sine/cosine of a binary angle. Each Horner step takes two
// stages: a Q30 multiply, then a divide by a small constant done as a
// reciprocal multiply and a subtract.
// Advances when i_en is high.
module e2r_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [ANGLE_BITS-1:0]    i_ang,
    output logic signed [31:0]       o_sin,
    output logic signed [31:0]       o_cos
);
    import e2r_pkg::*;

    localparam int NS   = 5;
    localparam int LAST = 2 * NS + 1;

    // stage 0: reduce to an eighth, radians in Q30
    logic [31:0]    w_p;
    logic [29:0]    w_u;
    logic [QW-1:0]  w_a;
    logic [63:0]    w_xp;
    logic [QW-1:0]  w_x;

    assign w_p  = {i_ang, {(32-ANGLE_BITS){1'b0}}};
    assign w_u  = w_p[29:0];
    assign w_a  = w_u[29] ? (Q30_ONE - {1'b0, w_u}) : {1'b0, w_u};
    assign w_xp = {33'd0, w_a} * {32'd0, QUARTER_PI_Q30} + 64'h1000_0000;
    assign w_x  = w_xp[QW+28:29];

    logic [QW-1:0] r_x  [0:LAST];
    logic [QW-1:0] r_x2 [1:LAST];
    logic [QW-1:0] r_ts [1:LAST];
    logic [QW-1:0] r_tc [1:LAST];
    logic          r_sw [0:LAST];
    logic [1:0]    r_q  [0:LAST];

    // stage 0 register holds x; square in stage 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= w_x;
            r_sw[0] <= w_u[29];
            r_q[0]  <= w_p[31:30];
            r_x[1]  <= r_x[0];
            r_x2[1] <= qmul(r_x[0], r_x[0]);
            r_ts[1] <= Q30_ONE;
            r_tc[1] <= Q30_ONE;
            r_sw[1] <= r_sw[0];
            r_q[1]  <= r_q[0];
        end
    end

    // Horner steps: product stage, then divide stage.
    // Dividends stay below 2^30, so n * ceil(2^(30+l)/k) >> (30+l) is exact.
    for (genvar g = 0; g < NS; g++) begin : g_step
        localparam int unsigned KS = 32'(ks(g));
        localparam int unsigned KC = 32'(kc(g));
        localparam int unsigned SS = 30 + $clog2(KS);
        localparam int unsigned SC = 30 + $clog2(KC);
        localparam logic [31:0] MS = 32'(((64'd1 << SS) + 64'(KS) - 64'd1) / 64'(KS));
        localparam logic [31:0] MC = 32'(((64'd1 << SC) + 64'(KC) - 64'd1) / 64'(KC));

        logic [69:0] w_qs, w_qc;
        assign w_qs = {39'd0, r_ts[2*g+2]} * {38'd0, MS};
        assign w_qc = {39'd0, r_tc[2*g+2]} * {38'd0, MC};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // product half
                r_x[2*g+2]  <= r_x[2*g+1];
                r_x2[2*g+2] <= r_x2[2*g+1];
                r_ts[2*g+2] <= qmul(r_x2[2*g+1], r_ts[2*g+1]);
                r_tc[2*g+2] <= qmul(r_x2[2*g+1], r_tc[2*g+1]);
                r_sw[2*g+2] <= r_sw[2*g+1];
                r_q[2*g+2]  <= r_q[2*g+1];
                // divide half
                r_x[2*g+3]  <= r_x[2*g+2];
                r_x2[2*g+3] <= r_x2[2*g+2];
                r_ts[2*g+3] <= Q30_ONE - w_qs[SS +: QW];
                r_tc[2*g+3] <= Q30_ONE - w_qc[SC +: QW];
                r_sw[2*g+3] <= r_sw[2*g+2];
                r_q[2*g+3]  <= r_q[2*g+2];
            end
        end
    end

    // final multiply, swap and quadrant fold
    logic [QW-1:0]      w_s, w_c;
    logic signed [31:0] w_sq, w_cq;
    assign w_s  = qmul(r_x[LAST], r_ts[LAST]);
    assign w_c  = Q30_ONE - (qmul(r_x2[LAST], r_tc[LAST]) >> 1);
    assign w_sq = r_sw[LAST] ? $signed({1'b0, w_c}) : $signed({1'b0, w_s});
    assign w_cq = r_sw[LAST] ? $signed({1'b0, w_s}) : $signed({1'b0, w_c});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[LAST])
                2'd0: begin o_sin <= w_sq;  o_cos <= w_cq;  end
                2'd1: begin o_sin <= w_cq;  o_cos <= -w_sq; end
                2'd2: begin o_sin <= -w_sq; o_cos <= -w_cq; end
                default: begin o_sin <= -w_cq; o_cos <= w_sq; end
            endcase
        end
    end
endmodule

/* rtl/e2r_matrix.sv */
// Matrix assembly: products, triple product rounding, sums, finish.
// Three register stages; advances when i_en is high.
module e2r_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_sy, i_cy, i_sp, i_cp, i_sr, i_cr,
    output e2r_pkg::t_out      o_m
);
    import e2r_pkg::*;

    localparam int SH = 60 - FRAC_BITS;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    function automatic logic signed [15:0] fin(input logic signed [63:0] q60);
        logic signed [63:0] v;
        v = rshift(q60, SH);
        if (v > ONE) v = ONE;
        if (v < -ONE) v = -ONE;
        fin = v[15:0];
    endfunction

    // stage A: pair products
    logic signed [63:0] r_sysp, r_cysp, r_sycp, r_cpsr, r_cpcr, r_cycp, r_sp;
    logic signed [63:0] r_cycr, r_cysr, r_sysr, r_sycr;
    logic signed [31:0] r_sr, r_cr;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sysp <= i_sy * i_sp;  r_cysp <= i_cy * i_sp;
            r_sycp <= i_sy * i_cp;  r_cpsr <= i_cp * i_sr;
            r_cpcr <= i_cp * i_cr;  r_cycp <= i_cy * i_cp;
            r_cycr <= i_cy * i_cr;  r_cysr <= i_cy * i_sr;
            r_sysr <= i_sy * i_sr;  r_sycr <= i_sy * i_cr;
            r_sp   <= 64'(i_sp) <<< 30;
            r_sr   <= i_sr;         r_cr   <= i_cr;
        end
    end

    // stage B: round pairs to Q30, multiply by roll terms
    logic signed [63:0] w_a, w_b;
    assign w_a = rshift(r_sysp, 30);
    assign w_b = rshift(r_cysp, 30);
    logic signed [63:0] r_t0, r_t1, r_t6, r_t7;
    logic signed [63:0] r_b_cycr, r_b_cysr, r_b_sysr, r_b_sycr;
    logic signed [63:0] r_b_sycp, r_b_cpsr, r_b_cpcr, r_b_cycp, r_b_sp;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0 <= $signed(w_a[31:0]) * r_sr;   r_t1 <= $signed(w_a[31:0]) * r_cr;
            r_t6 <= $signed(w_b[31:0]) * r_sr;   r_t7 <= $signed(w_b[31:0]) * r_cr;
            r_b_cycr <= r_cycr; r_b_cysr <= r_cysr;
            r_b_sysr <= r_sysr; r_b_sycr <= r_sycr;
            r_b_sycp <= r_sycp; r_b_cpsr <= r_cpsr;
            r_b_cpcr <= r_cpcr; r_b_cycp <= r_cycp; r_b_sp <= r_sp;
        end
    end

    // stage C: sums, rounding and clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m.m00 <= fin(r_b_cycr + r_t0);
            o_m.m01 <= fin(r_t1 - r_b_cysr);
            o_m.m02 <= fin(r_b_sycp);
            o_m.m10 <= fin(r_b_cpsr);
            o_m.m11 <= fin(r_b_cpcr);
            o_m.m12 <= fin(-r_b_sp);
            o_m.m20 <= fin(r_t6 - r_b_sycr);
            o_m.m21 <= fin(r_b_sysr + r_t7);
            o_m.m22 <= fin(r_b_cycp);
        end
    end
endmodule

/* rtl/euler_to_rotation_matrix.sv */
// Euler angles (yaw about y, pitch about x, roll about z) to rotation matrix.
// Input channel i_valid/o_ready carries one request of three binary angles
// (2^ANGLE_BITS = one turn, low bits used). Output channel o_valid/i_ready
// carries the nine elements of Ry*Rx*Rz, signed with FRAC_BITS fraction
// bits, rounded and saturated to +-1.0.
// Throughput: one request per cycle while the output is not stalled. The
// sin/cos pipeline has 13 stages (reduce, square, five Horner steps of two
// stages each, fold) and the matrix pipeline 3 stages (pair products,
// triple products, sum and round); the last matrix stage is the output.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipeline freezes and o_ready drops only if the
// output is full, so nothing is lost or repeated. Bubbles inside the
// pipeline are not removed; o_ready stays high while the output is empty.
// Reset clears all valid bits; no result is pending after reset.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  e2r_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output e2r_pkg::t_out  o_data
);
    import e2r_pkg::*;

    localparam int LAT = 16;

    logic [LAT-1:0] r_v;
    logic           w_en;

    // advance whenever the last stage can move on
    assign w_en    = !r_v[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    logic signed [31:0] w_sy, w_cy, w_sp, w_cp, w_sr, w_cr;

    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_ang(i_data.yaw_angle[ANGLE_BITS-1:0]),
        .o_sin(w_sy), .o_cos(w_cy));
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .i_clk(i_clk), .i_en(w_en), .i_ang(i_data.pitch_angle[ANGLE_BITS-1:0]),
        .o_sin(w_sp), .o_cos(w_cp));
    e2r_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .i_clk(i_clk), .i_en(w_en), .i_ang(i_data.roll_angle[ANGLE_BITS-1:0]),
        .o_sin(w_sr), .o_cos(w_cr));

    e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .i_clk(i_clk), .i_en(w_en),
        .i_sy(w_sy), .i_cy(w_cy), .i_sp(w_sp), .i_cp(w_cp),
        .i_sr(w_sr), .i_cr(w_cr), .o_m(o_data));
endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import e2r_pkg::*;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS = 14;
    localparam int LATENCY = 16;
    localparam int RANDOM_ITEMS = 950;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    t_in pending_angles[$];
    t_out expected_matrices[$];
    int error_count;
    int send_gap;
    int recv_gap;

    // handshake flag seen at the last rising edge
    logic o_ready_seen;

    euler_to_rotation_matrix #(
        .ANGLE_BITS(ANGLE_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // signed round-half-up of magnitude
    function automatic longint round_mag(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    // sine and cosine of an angle up to an eighth turn, Q30
    function automatic void octant_sincos(input longint a, output longint s,
                                          output longint c);
        longint sdiv[5];
        longint cdiv[5];
        longint x;
        longint x2;
        longint t;
        longint q30;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12};
        q30 = longint'(1) << 30;
        x = (a * 843314857 + (longint'(1) << 28)) >>> 29;
        x2 = (x * x + (q30 >>> 1)) >>> 30;
        t = q30;
        for (int i = 0; i < 5; i++)
            t = q30 - ((x2 * t + (q30 >>> 1)) >>> 30) / sdiv[i];
        s = (x * t + (q30 >>> 1)) >>> 30;
        t = q30;
        for (int i = 0; i < 5; i++)
            t = q30 - ((x2 * t + (q30 >>> 1)) >>> 30) / cdiv[i];
        c = q30 - ((x2 * t + (q30 >>> 1)) >>> 30) / 2;
    endfunction

    // full-turn sine/cosine by quadrant folding
    function automatic void angle_sincos(input logic [15:0] raw, output longint sn,
                                         output longint cs);
        logic [31:0] phase;
        logic [1:0] quad;
        longint resid;
        longint s;
        longint c;
        longint sq;
        longint cq;
        phase = 32'(raw[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        quad = phase[31:30];
        resid = longint'(phase[29:0]);
        if (resid < (longint'(1) << 29)) begin
            octant_sincos(resid, s, c);
            sq = s;
            cq = c;
        end else begin
            octant_sincos((longint'(1) << 30) - resid, s, c);
            sq = c;
            cq = s;
        end
        case (quad)
            2'd0: begin sn = sq;  cs = cq;  end
            2'd1: begin sn = cq;  cs = -sq; end
            2'd2: begin sn = -sq; cs = -cq; end
            default: begin sn = -cq; cs = sq; end
        endcase
    endfunction

    function automatic logic [15:0] to_fixed(input longint q60);
        longint one;
        longint v;
        one = longint'(1) << FRAC_BITS;
        v = round_mag(q60, 60 - FRAC_BITS);
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[15:0];
    endfunction

    function automatic t_out rotation_of(input t_in a);
        longint sy, cy, sp, cp, sr, cr;
        longint sysp;
        longint cysp;
        t_out m;
        angle_sincos(a.yaw_angle, sy, cy);
        angle_sincos(a.pitch_angle, sp, cp);
        angle_sincos(a.roll_angle, sr, cr);
        sysp = round_mag(sy * sp, 30);
        cysp = round_mag(cy * sp, 30);
        m.m00 = to_fixed(cy * cr + sysp * sr);
        m.m01 = to_fixed(sysp * cr - cy * sr);
        m.m02 = to_fixed(sy * cp);
        m.m10 = to_fixed(cp * sr);
        m.m11 = to_fixed(cp * cr);
        m.m12 = to_fixed(-sp * (longint'(1) << 30));
        m.m20 = to_fixed(cysp * sr - sy * cr);
        m.m21 = to_fixed(sy * sr + cysp * cr);
        m.m22 = to_fixed(cy * cp);
        return m;
    endfunction

    // mostly short gaps, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch %s got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        error_count++;
    endtask

    function automatic logic [15:0] random_angle();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'($urandom_range(3) << 14);
        if (r == 1) return 16'(($urandom_range(7) << 13) + $urandom_range(2) - 1);
        return 16'($urandom);
    endfunction

    // driver: requests change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
            send_gap <= 0;
        end else if (!i_valid || o_ready_seen) begin
            if (pending_angles.size() > 0 && send_gap == 0) begin
                i_valid <= 1'b1;
                i_data <= pending_angles.pop_front();
                send_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            i_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            i_ready <= 1'b1;
            recv_gap <= ($urandom_range(3) == 0) ? pick_gap() : 0;
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            o_ready_seen <= 1'b0;
        end else begin
            o_ready_seen <= i_valid && o_ready;
            if (i_valid && o_ready)
                expected_matrices.push_back(rotation_of(i_data));
            if (o_valid && i_ready) begin
                if (expected_matrices.size() == 0) begin
                    $display("%0t: result with nothing expected", $realtime);
                    error_count++;
                end else begin
                    want = expected_matrices.pop_front();
                    if (o_data.m00 !== want.m00) report_mismatch("m00", o_data.m00, want.m00);
                    if (o_data.m01 !== want.m01) report_mismatch("m01", o_data.m01, want.m01);
                    if (o_data.m02 !== want.m02) report_mismatch("m02", o_data.m02, want.m02);
                    if (o_data.m10 !== want.m10) report_mismatch("m10", o_data.m10, want.m10);
                    if (o_data.m11 !== want.m11) report_mismatch("m11", o_data.m11, want.m11);
                    if (o_data.m12 !== want.m12) report_mismatch("m12", o_data.m12, want.m12);
                    if (o_data.m20 !== want.m20) report_mismatch("m20", o_data.m20, want.m20);
                    if (o_data.m21 !== want.m21) report_mismatch("m21", o_data.m21, want.m21);
                    if (o_data.m22 !== want.m22) report_mismatch("m22", o_data.m22, want.m22);
                end
            end
        end
    end

    initial begin
        t_in a;
        logic [15:0] corners[10];
        corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                    16'hFFFF, 16'h2000, 16'h1FFF, 16'h2001, 16'h0001};
        error_count = 0;
        i_rst_n = 1'b0;
        // directed: quadrant boundaries, octant edge, field extremes
        for (int i = 0; i < 10; i++) begin
            a.yaw_angle = corners[i];
            a.pitch_angle = corners[(i + 3) % 10];
            a.roll_angle = corners[(i + 7) % 10];
            pending_angles.push_back(a);
        end
        for (int i = 0; i < 10; i++) begin
            a.yaw_angle = corners[i];
            a.pitch_angle = corners[i];
            a.roll_angle = corners[i];
            pending_angles.push_back(a);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            a.yaw_angle = random_angle();
            a.pitch_angle = random_angle();
            a.roll_angle = random_angle();
            pending_angles.push_back(a);
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_angles.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        wait (expected_matrices.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && expected_matrices.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
